// ===== hdl/qte_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the quaternion to Euler angle converter
package qte_pkg;

	// Input number format and internal working format
	localparam int QUAT_FRAC_BITS = 30;
	localparam int WORK_BITS      = 24;
	localparam int CORDIC_STEPS   = 16;
	localparam int CORDIC_ITERS   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	localparam int ITER_W         = $clog2(CORDIC_ITERS);

	// Widths of the working values
	localparam int WK_W   = 29;   // component in Q24, saturated to +-8.0
	localparam int MUL_W  = 32;   // multiplier operand
	localparam int PROD_W = 64;   // multiplier product
	localparam int ACC_W  = 58;   // Q48 sums and CORDIC vector
	localparam int Z_W    = 34;   // angle in centidegrees * 65536
	localparam int ROOT_W = 62;   // square root radicand and partial root
	localparam int SQ_W   = 31;   // square root result
	localparam int CENTI_W = 16;
	localparam int PITCH_W = 15;
	localparam int CNT_W   = 32;

	// Conversion of input components to Q24
	localparam int SHIFT_DN = (QUAT_FRAC_BITS >= WORK_BITS) ? QUAT_FRAC_BITS - WORK_BITS : 0;
	localparam int SHIFT_UP = (QUAT_FRAC_BITS < WORK_BITS) ? WORK_BITS - QUAT_FRAC_BITS : 0;
	localparam logic signed [34:0] SAT_LIM = 35'sd8 <<< QUAT_FRAC_BITS;

	// Fixed-point constants
	localparam logic signed [ACC_W-1:0]  ONE_Q48  = 58'sd1 <<< 48;
	localparam logic signed [PROD_W-1:0] ONE_Q60  = 64'sd1 <<< 60;
	localparam logic [ACC_W-1:0]         NORM_HI  = 58'd1 << 29;
	localparam logic [ACC_W-1:0]         NORM_LO  = 58'd1 << 28;
	localparam logic signed [Z_W-1:0]    ANG_HALF = 34'sd1179648000;
	localparam logic signed [Z_W-1:0]    ROUND_HALF = 34'sd32768;
	localparam logic signed [Z_W-1:0]    ROLL_LIM  = 34'sd18000;
	localparam logic signed [Z_W-1:0]    PITCH_LIM = 34'sd9000;
	localparam logic signed [16:0]       HALF_TURN = 17'sd18000;
	localparam logic signed [16:0]       FULL_TURN = 17'sd36000;
	localparam logic [4:0]               SQRT_TOP_K = 5'd30;

	// Operation codes of the input word
	localparam logic OP_SAMPLE    = 1'b0;
	localparam logic OP_YAW_RESET = 1'b1;

	typedef enum logic [1:0] {
		STAT_UPDATED   = 2'd0,
		STAT_NO_QUAT   = 2'd1,
		STAT_NOT_READY = 2'd2,
		STAT_YAW_RESET = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ANG_ROLL  = 2'd0,
		ANG_PITCH = 2'd1,
		ANG_YAW   = 2'd2
	} ang_sel_t;

	// Product schedule of the shared multiplier
	typedef enum logic [3:0] {
		MP_WX = 4'd0, MP_YZ = 4'd1, MP_XX = 4'd2, MP_YY = 4'd3, MP_WY = 4'd4,
		MP_ZX = 4'd5, MP_WZ = 4'd6, MP_XY = 4'd7, MP_ZZ = 4'd8, MP_SS = 4'd9
	} mul_pair_t;
	localparam logic [3:0] MUL_FLUSH = 4'd10;

	typedef enum logic [3:0] {
		CS_IDLE, CS_MUL, CS_ROLL_GO, CS_ROLL_WAIT, CS_SQRT_GO, CS_SQRT_WAIT,
		CS_PITCH_GO, CS_PITCH_WAIT, CS_YAW_GO, CS_YAW_WAIT, CS_EMIT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		CP_IDLE, CP_NORM, CP_ITER
	} cordic_phase_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic      load;
		logic      mul_go;
		mul_pair_t mul_idx;
		logic      atan_go;
		ang_sel_t  atan_sel;
		logic      sqrt_go;
		logic      emit;
		status_t   emit_status;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic atan_done;
		logic sqrt_done;
	} sts_t;

	// Saturate a raw component to +-8.0 and bring it to Q24
	function automatic logic signed [WK_W-1:0] to_work(input logic signed [31:0] raw);
		logic signed [34:0] v;
		logic signed [34:0] r;
		v = 35'(raw);
		if (v > SAT_LIM)
			v = SAT_LIM;
		if (v < -SAT_LIM)
			v = -SAT_LIM;
		r = (v >>> SHIFT_DN) <<< SHIFT_UP;
		return r[WK_W-1:0];
	endfunction

	// Arctangent of 2^-i in centidegrees * 65536
	function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			5'd0:    r = 34'sd294912000;
			5'd1:    r = 34'sd174096719;
			5'd2:    r = 34'sd91987925;
			5'd3:    r = 34'sd46694507;
			5'd4:    r = 34'sd23437865;
			5'd5:    r = 34'sd11730358;
			5'd6:    r = 34'sd5866610;
			5'd7:    r = 34'sd2933484;
			5'd8:    r = 34'sd1466764;
			5'd9:    r = 34'sd733385;
			5'd10:   r = 34'sd366693;
			5'd11:   r = 34'sd183346;
			5'd12:   r = 34'sd91673;
			5'd13:   r = 34'sd45837;
			5'd14:   r = 34'sd22918;
			5'd15:   r = 34'sd11459;
			5'd16:   r = 34'sd5730;
			5'd17:   r = 34'sd2865;
			5'd18:   r = 34'sd1432;
			5'd19:   r = 34'sd716;
			5'd20:   r = 34'sd358;
			5'd21:   r = 34'sd179;
			5'd22:   r = 34'sd90;
			5'd23:   r = 34'sd45;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Fold an angle difference back into -18000..18000 centidegrees
	function automatic logic signed [CENTI_W-1:0] wrap_centi(input logic signed [16:0] d);
		logic signed [16:0] r;
		if (d > HALF_TURN)
			r = d - FULL_TURN;
		else if (d < -HALF_TURN)
			r = d + FULL_TURN;
		else
			r = d;
		return r[CENTI_W-1:0];
	endfunction

endpackage

// ===== hdl/qte_cordic.sv =====
`timescale 1ns / 1ps
// Iterative vectoring CORDIC giving atan2 in centidegrees * 65536
module qte_cordic import qte_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] y_in,
	input  logic signed [ACC_W-1:0] x_in,
	output logic                    done,
	output logic signed [Z_W-1:0]   angle
);

	cordic_phase_t           phase_q;
	logic                    done_q;
	logic [ITER_W-1:0]       iter_q;
	logic signed [ACC_W-1:0] x_q;
	logic signed [ACC_W-1:0] y_q;
	logic [ACC_W-1:0]        m_q;
	logic signed [Z_W-1:0]   z_q;

	logic [ACC_W-1:0]        ax;
	logic [ACC_W-1:0]        ay;
	logic signed [ACC_W-1:0] dx;
	logic signed [ACC_W-1:0] dy;
	logic signed [Z_W-1:0]   tab;

	// Magnitudes of the operands and the shifted terms of one rotation
	always_comb begin
		ax  = x_in[ACC_W-1] ? ACC_W'(-x_in) : ACC_W'(x_in);
		ay  = y_in[ACC_W-1] ? ACC_W'(-y_in) : ACC_W'(y_in);
		dx  = y_q >>> iter_q;
		dy  = x_q >>> iter_q;
		tab = atan_entry(5'(iter_q));
	end

	// Sequence: fold to right half plane, normalise one bit a cycle, rotate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= CP_IDLE;
			done_q  <= 1'b0;
			iter_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				CP_IDLE: begin
					if (start) begin
						if (x_in == '0 && y_in == '0) begin
							done_q <= 1'b1;
						end else begin
							phase_q <= CP_NORM;
						end
					end
				end
				CP_NORM: begin
					if (m_q < NORM_HI && m_q >= NORM_LO) begin
						phase_q <= CP_ITER;
						iter_q  <= '0;
					end
				end
				CP_ITER: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(CORDIC_ITERS - 1)) begin
						phase_q <= CP_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= CP_IDLE;
			endcase
		end
	end

	// Vector and angle accumulator
	always_ff @(posedge clk) begin
		case (phase_q)
			CP_IDLE: begin
				if (start) begin
					m_q <= (ax > ay) ? ax : ay;
					if (x_in < 0) begin
						x_q <= -x_in;
						y_q <= -y_in;
						z_q <= (y_in >= 0) ? ANG_HALF : -ANG_HALF;
					end else begin
						x_q <= x_in;
						y_q <= y_in;
						z_q <= '0;
					end
				end
			end
			CP_NORM: begin
				if (m_q >= NORM_HI) begin
					x_q <= x_q >>> 1;
					y_q <= y_q >>> 1;
					m_q <= m_q >> 1;
				end else if (m_q < NORM_LO) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
					m_q <= m_q << 1;
				end
			end
			CP_ITER: begin
				if (y_q > 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + tab;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - tab;
				end
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign angle = z_q;

endmodule

// ===== hdl/qte_isqrt.sv =====
`timescale 1ns / 1ps
// Bit-serial floor integer square root, one result bit a cycle
module qte_isqrt import qte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ROOT_W-1:0] radicand,
	output logic              done,
	output logic [SQ_W-1:0]   root
);

	logic              run_q;
	logic              done_q;
	logic [4:0]        k_q;
	logic [ROOT_W-1:0] n_q;
	logic [ROOT_W-1:0] res_q;
	logic [ROOT_W-1:0] bitv;
	logic [ROOT_W-1:0] trial;

	// Current bit of the root and the trial subtrahend
	always_comb begin
		bitv  = ROOT_W'(1) << {k_q, 1'b0};
		trial = res_q + bitv;
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				k_q   <= SQRT_TOP_K;
			end else if (run_q) begin
				k_q <= k_q - 1'b1;
				if (k_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and partial root
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= radicand;
			res_q <= '0;
		end else if (run_q) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bitv;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign root = res_q[SQ_W-1:0];

endmodule

// ===== hdl/qte_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine sequencing the conversion of one word
module qte_ctrl import qte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write_en,
	input  logic cfg_write_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic operation,
	input  logic quat_valid,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        sensor_ready_q;
	status_t     status_q;
	status_t     status_d;
	logic [3:0]  mul_cnt_q;
	logic        out_valid_q;
	logic        accept;
	logic        out_free;
	logic        sample;

	assign accept   = in_valid && (state_q == CS_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign sample   = (operation == OP_SAMPLE) && sensor_ready_q && quat_valid;

	// Classify the incoming word
	always_comb begin
		if (operation == OP_YAW_RESET)
			status_d = STAT_YAW_RESET;
		else if (!sensor_ready_q)
			status_d = STAT_NOT_READY;
		else if (!quat_valid)
			status_d = STAT_NO_QUAT;
		else
			status_d = STAT_UPDATED;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE:       if (accept) state_d = sample ? CS_MUL : CS_EMIT;
			CS_MUL:        if (mul_cnt_q == MUL_FLUSH) state_d = CS_ROLL_GO;
			CS_ROLL_GO:    state_d = CS_ROLL_WAIT;
			CS_ROLL_WAIT:  if (sts.atan_done) state_d = CS_SQRT_GO;
			CS_SQRT_GO:    state_d = CS_SQRT_WAIT;
			CS_SQRT_WAIT:  if (sts.sqrt_done) state_d = CS_PITCH_GO;
			CS_PITCH_GO:   state_d = CS_PITCH_WAIT;
			CS_PITCH_WAIT: if (sts.atan_done) state_d = CS_YAW_GO;
			CS_YAW_GO:     state_d = CS_YAW_WAIT;
			CS_YAW_WAIT:   if (sts.atan_done) state_d = CS_EMIT;
			CS_EMIT:       if (out_free) state_d = CS_IDLE;
			default:       state_d = CS_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd             = '0;
		cmd.mul_idx     = MP_WX;
		cmd.atan_sel    = ANG_ROLL;
		cmd.emit_status = status_q;
		case (state_q)
			CS_IDLE: cmd.load = accept;
			CS_MUL: begin
				if (mul_cnt_q <= 4'(MP_SS)) begin
					cmd.mul_go  = 1'b1;
					cmd.mul_idx = mul_pair_t'(mul_cnt_q);
				end
			end
			CS_ROLL_GO: begin
				cmd.atan_go  = 1'b1;
				cmd.atan_sel = ANG_ROLL;
			end
			CS_SQRT_GO: cmd.sqrt_go = 1'b1;
			CS_PITCH_GO: begin
				cmd.atan_go  = 1'b1;
				cmd.atan_sel = ANG_PITCH;
			end
			CS_YAW_GO: begin
				cmd.atan_go  = 1'b1;
				cmd.atan_sel = ANG_YAW;
			end
			CS_EMIT: cmd.emit = out_free;
			default: ;
		endcase
	end

	// State, status, product counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= CS_IDLE;
			sensor_ready_q <= 1'b0;
			status_q       <= STAT_UPDATED;
			mul_cnt_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en)
				sensor_ready_q <= cfg_write_data;
			if (accept)
				status_q <= status_d;
			if (state_q == CS_MUL)
				mul_cnt_q <= mul_cnt_q + 1'b1;
			else
				mul_cnt_q <= '0;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != CS_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== hdl/qte_dp.sv =====
`timescale 1ns / 1ps
// Datapath: shared multiplier, CORDIC and square root units, angle state, result register
module qte_dp import qte_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic signed [31:0]        quat_w,
	input  logic signed [31:0]        quat_x,
	input  logic signed [31:0]        quat_y,
	input  logic signed [31:0]        quat_z,
	output logic [1:0]                status,
	output logic signed [CENTI_W-1:0] roll_angle,
	output logic signed [PITCH_W-1:0] pitch_angle,
	output logic signed [CENTI_W-1:0] yaw_angle,
	output logic [CNT_W-1:0]          update_count
);

	// Working components
	logic signed [WK_W-1:0] w_q, x_q, y_q, z_q;

	// Multiplier stage
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	mul_pair_t                pair_s1;
	logic                     pv_s1;
	logic signed [ACC_W-1:0]  p2;

	// Q48 sums and square root radicand
	logic signed [ACC_W-1:0] ry_q, rx_q, s48_q, yy_q, yx_q;
	logic signed [ACC_W-1:0] s48_c;
	logic signed [ACC_W-1:0] s30_full;
	logic signed [MUL_W-1:0] s30;
	logic [ROOT_W-1:0]       nrad_q;

	// Shared units
	logic signed [ACC_W-1:0] at_y, at_x;
	logic                    at_done;
	logic signed [Z_W-1:0]   at_angle;
	logic                    sq_done;
	logic [SQ_W-1:0]         sq_root;
	ang_sel_t                sel_q;
	logic signed [Z_W-1:0]   cent_full;
	logic signed [Z_W-1:0]   cent_lim;
	logic signed [Z_W-1:0]   cent_c;

	// Angles of this word and the kept state
	logic signed [CENTI_W-1:0] roll_q, pitch_q, yaw_abs_q;
	logic signed [CENTI_W-1:0] yaw_offset_q, last_roll_q, last_yaw_q;
	logic signed [PITCH_W-1:0] last_pitch_q;
	logic [CNT_W-1:0]          sample_cnt_q;
	logic signed [CENTI_W-1:0] yaw_rel, yaw_fold;

	// Result register
	logic [1:0]                res_status_q;
	logic signed [CENTI_W-1:0] res_roll_q, res_yaw_q;
	logic signed [PITCH_W-1:0] res_pitch_q;
	logic [CNT_W-1:0]          res_cnt_q;

	// Latch the word's components in Q24
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q <= to_work(quat_w);
			x_q <= to_work(quat_x);
			y_q <= to_work(quat_y);
			z_q <= to_work(quat_z);
		end
	end

	// Clamp the pitch sine term and take it to Q30
	always_comb begin
		if (s48_q > ONE_Q48)
			s48_c = ONE_Q48;
		else if (s48_q < -ONE_Q48)
			s48_c = -ONE_Q48;
		else
			s48_c = s48_q;
		s30_full = s48_c >>> 18;
		s30      = s30_full[MUL_W-1:0];
	end

	// Pick the operand pair for the multiplier
	always_comb begin
		case (cmd.mul_idx)
			MP_WX:   begin mul_a = MUL_W'(w_q); mul_b = MUL_W'(x_q); end
			MP_YZ:   begin mul_a = MUL_W'(y_q); mul_b = MUL_W'(z_q); end
			MP_XX:   begin mul_a = MUL_W'(x_q); mul_b = MUL_W'(x_q); end
			MP_YY:   begin mul_a = MUL_W'(y_q); mul_b = MUL_W'(y_q); end
			MP_WY:   begin mul_a = MUL_W'(w_q); mul_b = MUL_W'(y_q); end
			MP_ZX:   begin mul_a = MUL_W'(z_q); mul_b = MUL_W'(x_q); end
			MP_WZ:   begin mul_a = MUL_W'(w_q); mul_b = MUL_W'(z_q); end
			MP_XY:   begin mul_a = MUL_W'(x_q); mul_b = MUL_W'(y_q); end
			MP_ZZ:   begin mul_a = MUL_W'(z_q); mul_b = MUL_W'(z_q); end
			MP_SS:   begin mul_a = s30;         mul_b = s30;         end
			default: begin mul_a = '0;          mul_b = '0;          end
		endcase
	end

	// Register the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pv_s1 <= 1'b0;
		else
			pv_s1 <= cmd.mul_go;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		pair_s1 <= cmd.mul_idx;
	end

	assign p2 = ACC_W'(prod_s1) <<< 1;

	// Accumulate twice each product into its sum; the last product sets the radicand to one minus it
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ry_q  <= '0;
			rx_q  <= ONE_Q48;
			s48_q <= '0;
			yy_q  <= '0;
			yx_q  <= ONE_Q48;
		end else if (pv_s1) begin
			case (pair_s1)
				MP_WX, MP_YZ: ry_q <= ry_q + p2;
				MP_XX:        rx_q <= rx_q - p2;
				MP_YY: begin
					rx_q <= rx_q - p2;
					yx_q <= yx_q - p2;
				end
				MP_WY:        s48_q <= s48_q + p2;
				MP_ZX:        s48_q <= s48_q - p2;
				MP_WZ, MP_XY: yy_q <= yy_q + p2;
				MP_ZZ:        yx_q <= yx_q - p2;
				MP_SS:        nrad_q <= ROOT_W'(ONE_Q60 - prod_s1);
				default: ;
			endcase
		end
	end

	// Operands for the shared atan2 unit
	always_comb begin
		case (cmd.atan_sel)
			ANG_ROLL:  begin at_y = ry_q;         at_x = rx_q; end
			ANG_PITCH: begin at_y = ACC_W'(s30);  at_x = ACC_W'({1'b0, sq_root}); end
			ANG_YAW:   begin at_y = yy_q;         at_x = yx_q; end
			default:   begin at_y = '0;           at_x = '0; end
		endcase
	end

	qte_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.atan_go),
		.y_in   (at_y),
		.x_in   (at_x),
		.done   (at_done),
		.angle  (at_angle)
	);

	qte_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_go),
		.radicand (nrad_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign sts.atan_done = at_done;
	assign sts.sqrt_done = sq_done;

	// Round to centidegrees and clamp to the angle's range
	always_comb begin
		cent_full = (at_angle + ROUND_HALF) >>> 16;
		cent_lim  = (sel_q == ANG_PITCH) ? PITCH_LIM : ROLL_LIM;
		if (cent_full > cent_lim)
			cent_c = cent_lim;
		else if (cent_full < -cent_lim)
			cent_c = -cent_lim;
		else
			cent_c = cent_full;
	end

	// Hold the angle selector and capture finished angles
	always_ff @(posedge clk) begin
		if (cmd.atan_go)
			sel_q <= cmd.atan_sel;
		if (at_done) begin
			case (sel_q)
				ANG_ROLL:  roll_q    <= cent_c[CENTI_W-1:0];
				ANG_PITCH: pitch_q   <= cent_c[CENTI_W-1:0];
				ANG_YAW:   yaw_abs_q <= cent_c[CENTI_W-1:0];
				default: ;
			endcase
		end
	end

	assign yaw_rel  = wrap_centi(17'(yaw_abs_q) - 17'(yaw_offset_q));
	assign yaw_fold = wrap_centi(17'(last_yaw_q) + 17'(yaw_offset_q));

	// Commit the kept state when the result is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_offset_q <= '0;
			last_roll_q  <= '0;
			last_pitch_q <= '0;
			last_yaw_q   <= '0;
			sample_cnt_q <= '0;
		end else if (cmd.emit) begin
			case (cmd.emit_status)
				STAT_UPDATED: begin
					last_roll_q  <= roll_q;
					last_pitch_q <= pitch_q[PITCH_W-1:0];
					last_yaw_q   <= yaw_rel;
					sample_cnt_q <= sample_cnt_q + 1'b1;
				end
				STAT_YAW_RESET: begin
					yaw_offset_q <= yaw_fold;
					last_yaw_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_status_q <= cmd.emit_status;
			case (cmd.emit_status)
				STAT_UPDATED: begin
					res_roll_q  <= roll_q;
					res_pitch_q <= pitch_q[PITCH_W-1:0];
					res_yaw_q   <= yaw_rel;
					res_cnt_q   <= sample_cnt_q + 1'b1;
				end
				STAT_YAW_RESET: begin
					res_roll_q  <= last_roll_q;
					res_pitch_q <= last_pitch_q;
					res_yaw_q   <= '0;
					res_cnt_q   <= sample_cnt_q;
				end
				default: begin
					res_roll_q  <= last_roll_q;
					res_pitch_q <= last_pitch_q;
					res_yaw_q   <= last_yaw_q;
					res_cnt_q   <= sample_cnt_q;
				end
			endcase
		end
	end

	assign status       = res_status_q;
	assign roll_angle   = res_roll_q;
	assign pitch_angle  = res_pitch_q;
	assign yaw_angle    = res_yaw_q;
	assign update_count = res_cnt_q;

endmodule

// ===== hdl/quaternion_to_euler_angles.sv =====
`timescale 1ns / 1ps
// Top level: quaternion to roll, pitch and yaw converter
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_stall  | operation, quat_valid, quat_w/x/y/z
//  out     | out_valid/out_stall| status, roll_angle, pitch_angle, yaw_angle, update_count
//  cfg     | cfg_write_en       | cfg_write_data (sensor ready)
//
// A status-only or yaw-reset word goes straight to the result; a quaternion sample passes
// through the shared multiplier, the roll CORDIC pass, the square root and the pitch and
// yaw CORDIC passes, each pass normalising the vector and then making 16 rotations; a
// zero vector cuts its pass short.
// Reset clears the controller, the sensor-ready register, yaw offset, angles and count.
// A word is taken while the previous result waits; a stalled result holds the next.
module quaternion_to_euler_angles import qte_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write_en,
	input  logic                      cfg_write_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  logic                      quat_valid,
	input  logic signed [31:0]        quat_w,
	input  logic signed [31:0]        quat_x,
	input  logic signed [31:0]        quat_y,
	input  logic signed [31:0]        quat_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic signed [CENTI_W-1:0] roll_angle,
	output logic signed [PITCH_W-1:0] pitch_angle,
	output logic signed [CENTI_W-1:0] yaw_angle,
	output logic [CNT_W-1:0]          update_count
);

	cmd_t cmd;
	sts_t sts;

	qte_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.quat_valid     (quat_valid),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.sts            (sts)
	);

	qte_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.quat_w       (quat_w),
		.quat_x       (quat_x),
		.quat_y       (quat_y),
		.quat_z       (quat_z),
		.status       (status),
		.roll_angle   (roll_angle),
		.pitch_angle  (pitch_angle),
		.yaw_angle    (yaw_angle),
		.update_count (update_count)
	);

	// A taken word keeps the input closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open right after a word was taken");

	// A yaw reset always reports zero relative yaw
	a_yaw_reset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_YAW_RESET) |-> (yaw_angle == '0))
		else $error("yaw reset result with non-zero yaw");

	// Reported pitch stays within a quarter turn
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_angle <= 15'sd9000 && pitch_angle >= -15'sd9000))
		else $error("pitch out of range");

	// The count moves only with an updated result
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_status != STAT_UPDATED) |=> (update_count == $past(u_dp.sample_cnt_q)))
		else $error("sample count changed without an update");

endmodule
